### rtl/core/gtuc_pkg.sv
// ----------------------------------------------------------------------------
// gtuc_pkg
// Types, constants and the leap-second round function for the GPS week /
// time-of-week to UTC calendar converter.
// ----------------------------------------------------------------------------
package gtuc_pkg;

  // Field widths
  localparam int WEEK_W   = 16;
  localparam int MILLIS_W = 30;
  localparam int DAYS_W   = 19;   // whole days since the GPS epoch
  localparam int MSD_W    = 27;   // milliseconds of day
  localparam int LEAP_W   = 4;
  localparam int MOD_W    = 11;   // minute of day, 0..1439
  localparam int MMS_W    = 16;   // milliseconds of minute
  localparam int C_W      = 13;   // year-like count from the day-number split
  localparam int B_W      = 22;
  localparam int BD_W     = 9;    // day within the March-based year, 123..488
  localparam int X_W      = 29;
  localparam int E_W      = 4;

  // Time constants
  localparam int MS_PER_DAY    = 86400000;
  localparam int MS_PER_MINUTE = 60000;
  localparam int MIN_PER_HOUR  = 60;
  localparam logic [MILLIS_W-1:0] MS_PER_WEEK = 30'd604800000;
  localparam int DAYS_PER_WEEK = 7;

  // Leap-second table: days from the GPS epoch to each step
  localparam int NUM_LEAPS   = 15;
  localparam int LEAP_ROUNDS = 4;
  localparam logic [NUM_LEAPS-1:0][DAYS_W-1:0] LEAP_DAY = {
    19'd10588, 19'd9492, 19'd6935, 19'd6386, 19'd5839, 19'd5290, 19'd4925,
    19'd4560,  19'd4013, 19'd3648, 19'd2917, 19'd2003, 19'd1272, 19'd907,
    19'd542
  };

  // Day-number algorithm offsets
  localparam int B_OFFSET  = 2445782;              // 2444245 + 1537
  localparam int X_OFFSET  = 100 * B_OFFSET - 12210;
  localparam int YEAR_BASE = 4715;
  localparam int CENT_DAYS = 36525;                // 365.25 scaled by 100

  // Reciprocals: floor(x / d) = (x * ceil(2^s / d)) >> s for x < 2^N,
  // with s = N + ceil(log2(d))
  localparam int YEAR_SHIFT   = 45;                // N = 29, d = 36525
  localparam int YEAR_RECIP_W = 30;
  localparam logic [63:0] YEAR_RECIP_WIDE =
    ((64'd1 << YEAR_SHIFT) + 64'(CENT_DAYS - 1)) / 64'(CENT_DAYS);
  localparam logic [YEAR_RECIP_W-1:0] YEAR_RECIP = YEAR_RECIP_WIDE[YEAR_RECIP_W-1:0];
  localparam int YPROD_W = X_W + YEAR_RECIP_W;

  localparam int MIN_SHIFT   = 43;                 // N = 27, d = 60000
  localparam int MIN_RECIP_W = 28;
  localparam logic [63:0] MIN_RECIP_WIDE =
    ((64'd1 << MIN_SHIFT) + 64'd59999) / 64'd60000;
  localparam logic [MIN_RECIP_W-1:0] MIN_RECIP = MIN_RECIP_WIDE[MIN_RECIP_W-1:0];
  localparam int MPROD_W = MSD_W + MIN_RECIP_W;

  localparam int HOUR_SHIFT   = 17;                // N = 11, d = 60
  localparam int HOUR_RECIP_W = 12;
  localparam logic [63:0] HOUR_RECIP_WIDE =
    ((64'd1 << HOUR_SHIFT) + 64'd59) / 64'd60;
  localparam logic [HOUR_RECIP_W-1:0] HOUR_RECIP = HOUR_RECIP_WIDE[HOUR_RECIP_W-1:0];
  localparam int HPROD_W = 22;

  // Month index thresholds: e steps up when bd >= ceil(30.6001 * k), k = 5..15
  localparam int NUM_E_THR = 11;
  localparam int E_MIN     = 4;
  localparam logic [NUM_E_THR-1:0][BD_W-1:0] E_THR = {
    9'd460, 9'd429, 9'd398, 9'd368, 9'd337, 9'd307, 9'd276, 9'd245, 9'd215,
    9'd184, 9'd154
  };
  // floor(30.6001 * e), indexed by e (only 4..15 occur)
  localparam logic [15:0][BD_W-1:0] DAY_BASE = {
    9'd459, 9'd428, 9'd397, 9'd367, 9'd336, 9'd306, 9'd275, 9'd244,
    9'd214, 9'd183, 9'd153, 9'd122, 9'd0,   9'd0,   9'd0,   9'd0
  };
  localparam logic [E_W-1:0] E_YEAR_WRAP = 4'd14;
  localparam logic [3:0]     MONTH_FEB   = 4'd2;

  // Payloads
  typedef struct packed {
    logic [WEEK_W-1:0]   week_number;
    logic [MILLIS_W-1:0] week_millis;
  } cal_in_t;

  typedef struct packed {
    logic [11:0]       cal_year;
    logic [3:0]        cal_month;
    logic [4:0]        cal_day;
    logic [4:0]        cal_hour;
    logic [5:0]        cal_minute;
    logic [MMS_W-1:0]  minute_millis;
    logic [LEAP_W-1:0] leap_count;
    logic              range_error;
  } cal_out_t;

  // Result of one leap round
  typedef struct packed {
    logic [DAYS_W-1:0] days;
    logic [MSD_W-1:0]  msd;
    logic [LEAP_W-1:0] leap;
  } round_t;

  // Context carried through the leap rounds
  typedef struct packed {
    logic                err;
    logic [DAYS_W-1:0]   week7;
    logic [MILLIS_W-1:0] millis;
    round_t              rnd;
  } lctx_t;

  // Fields handed from the calendar pipe to the output stage
  typedef struct packed {
    logic              err;
    logic [11:0]       year;
    logic [3:0]        month;
    logic [4:0]        day;
    logic [4:0]        hour;
    logic [MOD_W-1:0]  mod;
    logic [MMS_W-1:0]  mms;
    logic [LEAP_W-1:0] leap;
  } cal_fields_t;

  // One round: UTC = GPS - leap seconds, split into days and ms of day,
  // then count the leap thresholds at or below that day.
  function automatic round_t leap_round(input logic [DAYS_W-1:0]   week7,
                                        input logic [MILLIS_W-1:0] millis,
                                        input logic [LEAP_W-1:0]   leap);
    round_t             res;
    logic [13:0]        leap_ms;
    logic signed [31:0] rel;
    logic [2:0]         q;
    logic [31:0]        msd_full;
    logic [DAYS_W-1:0]  days;
    logic [LEAP_W-1:0]  cnt;
    leap_ms = 14'(leap) * 14'd1000;
    rel     = $signed({2'b00, millis}) - $signed({18'd0, leap_ms});
    // whole days within the week, 0..7
    q = '0;
    for (int k = 1; k <= DAYS_PER_WEEK; k++) begin
      if (!rel[31] && (rel[30:0] >= 31'(k * MS_PER_DAY))) q = q + 3'd1;
    end
    if (rel[31]) begin
      days     = week7 - DAYS_W'(1);
      msd_full = $unsigned(rel) + 32'(MS_PER_DAY);
    end else begin
      days     = week7 + DAYS_W'(q);
      msd_full = $unsigned(rel) - 32'(q) * 32'(MS_PER_DAY);
    end
    // threshold count; on a threshold counts as after it
    cnt = '0;
    for (int i = 0; i < NUM_LEAPS; i++) begin
      if (days >= LEAP_DAY[i]) cnt = cnt + LEAP_W'(1);
    end
    res.days = days;
    res.msd  = msd_full[MSD_W-1:0];
    res.leap = cnt;
    return res;
  endfunction

endpackage

### rtl/core/gtuc_leap_stage.sv
// ----------------------------------------------------------------------------
// gtuc_leap_stage
// One registered leap-second round: estimate UTC from the current count and
// look the count up again for that time.
// ----------------------------------------------------------------------------
module gtuc_leap_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  gtuc_pkg::lctx_t up_ctx,
  output logic            dn_valid,
  input  logic            dn_ready,
  output gtuc_pkg::lctx_t dn_ctx
);
  import gtuc_pkg::*;

  logic  valid_r;
  lctx_t ctx_r;
  lctx_t ctx_nxt;

  // stage moves when empty or when downstream takes its transaction
  assign up_ready = !valid_r || dn_ready;

  // round logic
  always_comb begin
    ctx_nxt     = up_ctx;
    ctx_nxt.rnd = leap_round(up_ctx.week7, up_ctx.millis, up_ctx.rnd.leap);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      ctx_r <= ctx_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_ctx   = ctx_r;

endmodule

### rtl/core/gtuc_cal_pipe.sv
// ----------------------------------------------------------------------------
// gtuc_cal_pipe
// Four-stage split of UTC days and ms of day into year, month, day, hour,
// minute of day and ms of minute (day-number algorithm in integer form).
// ----------------------------------------------------------------------------
module gtuc_cal_pipe (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  gtuc_pkg::lctx_t       up_ctx,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output gtuc_pkg::cal_fields_t dn_fields
);
  import gtuc_pkg::*;

  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;
  logic s1_ready, s2_ready, s3_ready, s4_ready;

  // stage 1: scaled day number and minute-of-day product
  logic [X_W-1:0]     s1_x_r, s1_x_nxt;
  logic [B_W-1:0]     s1_b_r, s1_b_nxt;
  logic [MPROD_W-1:0] s1_mprod_r, s1_mprod_nxt;
  logic [MSD_W-1:0]   s1_msd_r;
  logic [LEAP_W-1:0]  s1_leap_r;
  logic               s1_err_r;

  // stage 2: year product, minute of day
  logic [YPROD_W-1:0] s2_yprod_r, s2_yprod_nxt;
  logic [B_W-1:0]     s2_b_r;
  logic [MOD_W-1:0]   s2_mod_r, s2_mod_nxt;
  logic [MSD_W-1:0]   s2_msd_r;
  logic [LEAP_W-1:0]  s2_leap_r;
  logic               s2_err_r;

  // stage 3: year count, day within year, ms of minute, hour product
  logic [C_W-1:0]     s3_c_r, s3_c_nxt;
  logic [BD_W-1:0]    s3_bd_r, s3_bd_nxt;
  logic [MMS_W-1:0]   s3_mms_r, s3_mms_nxt;
  logic [HPROD_W-1:0] s3_hprod_r, s3_hprod_nxt;
  logic [MOD_W-1:0]   s3_mod_r;
  logic [LEAP_W-1:0]  s3_leap_r;
  logic               s3_err_r;
  logic [23:0]        s3_d_full;
  logic [B_W-1:0]     s3_d, s3_bd_full;
  logic [MSD_W-1:0]   s3_mms_full;

  // stage 4: month, day, year, hour
  cal_fields_t        s4_f_r, s4_f_nxt;
  logic [E_W-1:0]     s4_e;
  logic [3:0]         s4_month;
  logic [BD_W-1:0]    s4_day_full;
  logic [C_W-1:0]     s4_year_full;

  // handshake chain
  assign s4_ready = !s4_valid_r || dn_ready;
  assign s3_ready = !s3_valid_r || s4_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign up_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= up_valid;
      if (s2_ready) s2_valid_r <= s1_valid_r;
      if (s3_ready) s3_valid_r <= s2_valid_r;
      if (s4_ready) s4_valid_r <= s3_valid_r;
    end
  end

  // stage 1 logic
  always_comb begin
    s1_x_nxt     = X_W'(32'(up_ctx.rnd.days) * 32'd100 + 32'(X_OFFSET));
    s1_b_nxt     = B_W'(32'(up_ctx.rnd.days) + 32'(B_OFFSET));
    s1_mprod_nxt = MPROD_W'(up_ctx.rnd.msd) * MPROD_W'(MIN_RECIP);
  end

  always_ff @(posedge clk) begin
    if (s1_ready && up_valid) begin
      s1_x_r     <= s1_x_nxt;
      s1_b_r     <= s1_b_nxt;
      s1_mprod_r <= s1_mprod_nxt;
      s1_msd_r   <= up_ctx.rnd.msd;
      s1_leap_r  <= up_ctx.rnd.leap;
      s1_err_r   <= up_ctx.err;
    end
  end

  // stage 2 logic
  always_comb begin
    s2_yprod_nxt = YPROD_W'(s1_x_r) * YPROD_W'(YEAR_RECIP);
    s2_mod_nxt   = s1_mprod_r[MIN_SHIFT +: MOD_W];
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      s2_yprod_r <= s2_yprod_nxt;
      s2_b_r     <= s1_b_r;
      s2_mod_r   <= s2_mod_nxt;
      s2_msd_r   <= s1_msd_r;
      s2_leap_r  <= s1_leap_r;
      s2_err_r   <= s1_err_r;
    end
  end

  // stage 3 logic
  always_comb begin
    s3_c_nxt     = s2_yprod_r[YEAR_SHIFT +: C_W];
    s3_d_full    = 24'(s3_c_nxt) * 24'd1461;
    s3_d         = s3_d_full[23:2];
    s3_bd_full   = s2_b_r - s3_d;
    s3_bd_nxt    = s3_bd_full[BD_W-1:0];
    s3_mms_full  = s2_msd_r - MSD_W'(s2_mod_r) * MSD_W'(MS_PER_MINUTE);
    s3_mms_nxt   = s3_mms_full[MMS_W-1:0];
    s3_hprod_nxt = HPROD_W'(s2_mod_r) * HPROD_W'(HOUR_RECIP);
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid_r) begin
      s3_c_r     <= s3_c_nxt;
      s3_bd_r    <= s3_bd_nxt;
      s3_mms_r   <= s3_mms_nxt;
      s3_hprod_r <= s3_hprod_nxt;
      s3_mod_r   <= s2_mod_r;
      s3_leap_r  <= s2_leap_r;
      s3_err_r   <= s2_err_r;
    end
  end

  // stage 4 logic: month index by threshold count, then fields
  always_comb begin
    s4_e = E_W'(E_MIN);
    for (int k = 0; k < NUM_E_THR; k++) begin
      if (s3_bd_r >= E_THR[k]) s4_e = s4_e + E_W'(1);
    end
    s4_day_full = s3_bd_r - DAY_BASE[s4_e];
    if (s4_e < E_YEAR_WRAP) begin
      s4_month = s4_e - 4'd1;
    end else begin
      s4_month = s4_e - 4'd13;
    end
    s4_year_full   = s3_c_r - C_W'(YEAR_BASE) - C_W'(s4_month > MONTH_FEB);
    s4_f_nxt.err   = s3_err_r;
    s4_f_nxt.year  = s4_year_full[11:0];
    s4_f_nxt.month = s4_month;
    s4_f_nxt.day   = s4_day_full[4:0];
    s4_f_nxt.hour  = s3_hprod_r[HOUR_SHIFT +: 5];
    s4_f_nxt.mod   = s3_mod_r;
    s4_f_nxt.mms   = s3_mms_r;
    s4_f_nxt.leap  = s3_leap_r;
  end

  always_ff @(posedge clk) begin
    if (s4_ready && s3_valid_r) begin
      s4_f_r <= s4_f_nxt;
    end
  end

  assign dn_valid  = s4_valid_r;
  assign dn_fields = s4_f_r;

endmodule

### rtl/core/gps_time_to_utc_calendar_core.sv
// Throughput: one transaction per cycle, sustained while out_ready stays high.
// The pipeline has ten registers: input, four leap rounds, four calendar
// stages and the output register. Stalls hold every stage.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// gps_time_to_utc_calendar_core
// GPS week and time of week (ms) to UTC calendar date and time, with the
// leap-second count settled over four table-lookup rounds.
// ----------------------------------------------------------------------------
module gps_time_to_utc_calendar_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  gtuc_pkg::cal_in_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output gtuc_pkg::cal_out_t out_data
);
  import gtuc_pkg::*;

  // input stage
  logic  in_valid_r;
  lctx_t in_ctx_r, in_ctx_nxt;

  // leap round chain
  logic        stg_valid [LEAP_ROUNDS+1];
  logic        stg_ready [LEAP_ROUNDS+1];
  lctx_t       stg_ctx   [LEAP_ROUNDS+1];

  // calendar pipe
  logic        cal_valid;
  logic        cal_ready;
  cal_fields_t cal_f;

  // output stage
  logic        out_valid_r;
  cal_out_t    out_data_r, out_data_nxt;
  logic [MOD_W-1:0] minute_full;

  assign in_ready = !in_valid_r || stg_ready[0];

  // range check and week scaling
  always_comb begin
    in_ctx_nxt          = '0;
    in_ctx_nxt.err      = in_data.week_millis > MS_PER_WEEK;
    in_ctx_nxt.week7    = DAYS_W'({in_data.week_number, 3'b000}) -
                          DAYS_W'(in_data.week_number);
    in_ctx_nxt.millis   = in_data.week_millis;
    in_ctx_nxt.rnd.leap = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_ctx_r <= in_ctx_nxt;
    end
  end

  assign stg_valid[0] = in_valid_r;
  assign stg_ctx[0]   = in_ctx_r;

  // leap-second rounds
  for (genvar g = 0; g < LEAP_ROUNDS; g++) begin : g_round
    gtuc_leap_stage u_round (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[g]),
      .up_ready (stg_ready[g]),
      .up_ctx   (stg_ctx[g]),
      .dn_valid (stg_valid[g+1]),
      .dn_ready (stg_ready[g+1]),
      .dn_ctx   (stg_ctx[g+1])
    );
  end

  gtuc_cal_pipe u_cal (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (stg_valid[LEAP_ROUNDS]),
    .up_ready  (stg_ready[LEAP_ROUNDS]),
    .up_ctx    (stg_ctx[LEAP_ROUNDS]),
    .dn_valid  (cal_valid),
    .dn_ready  (cal_ready),
    .dn_fields (cal_f)
  );

  // output register: minute of hour, error zeroing
  assign cal_ready = !out_valid_r || out_ready;

  always_comb begin
    minute_full = cal_f.mod - MOD_W'(cal_f.hour) * MOD_W'(MIN_PER_HOUR);
    out_data_nxt = '0;
    if (cal_f.err) begin
      out_data_nxt.range_error = 1'b1;
    end else begin
      out_data_nxt.cal_year      = cal_f.year;
      out_data_nxt.cal_month     = cal_f.month;
      out_data_nxt.cal_day       = cal_f.day;
      out_data_nxt.cal_hour      = cal_f.hour;
      out_data_nxt.cal_minute    = minute_full[5:0];
      out_data_nxt.minute_millis = cal_f.mms;
      out_data_nxt.leap_count    = cal_f.leap;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cal_ready) begin
      out_valid_r <= cal_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cal_ready && cal_valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### test/gps_time_to_utc_calendar_core_test.sv
// ----------------------------------------------------------------------------
// gps_time_to_utc_calendar_core_test
// Self-checking bench for the GPS-to-UTC calendar converter. Fixes (week,
// time of week) are pushed through the valid/ready input while the result
// side stalls at random. Each accepted transaction is predicted in the
// bench and compared field by field against the converter output in order.
// ----------------------------------------------------------------------------
module gps_time_to_utc_calendar_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gtuc_pkg::*;

  localparam longint MS_IN_DAY    = 64'd86400000;
  localparam longint MS_IN_WEEK   = 64'd604800000;
  localparam longint JD_AT_EPOCH  = 64'd2444245;
  localparam longint TOW_MAX      = 64'd1073741823;
  localparam int     SETTLE_STEPS = 4;

  // leap-second steps, days after the GPS epoch
  localparam int STEP_DAYS [15] = '{
    542, 907, 1272, 2003, 2917, 3648, 4013, 4560,
    4925, 5290, 5839, 6386, 6935, 9492, 10588
  };

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     out_ready = 1'b0;
  cal_in_t  in_data   = '0;
  logic     in_ready;
  logic     out_valid;
  cal_out_t out_data;

  cal_out_t utc_expect_q[$];
  int       error_count = 0;
  bit       idle_on     = 1'b1;
  int       stall_left  = 0;

  gps_time_to_utc_calendar_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------
  function automatic longint floor_quot(input longint num, input longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  // thresholds at or below this UTC time; on the step counts as after it
  function automatic int leap_steps_at(input longint utc_ms);
    int n;
    n = 0;
    for (int i = 0; i < 15; i++) begin
      if (utc_ms >= longint'(STEP_DAYS[i]) * MS_IN_DAY) n++;
    end
    return n;
  endfunction

  function automatic cal_out_t predict_utc_date(input cal_in_t fix);
    cal_out_t r;
    longint   gps_ms, utc_ms, days, msd;
    longint   a, b, c, d, e, dom, mon, yr;
    int       leap;
    r = '0;
    if (longint'(fix.week_millis) > MS_IN_WEEK) begin
      r.range_error = 1'b1;
      return r;
    end
    gps_ms = longint'(fix.week_number) * MS_IN_WEEK + longint'(fix.week_millis);
    utc_ms = gps_ms;
    leap   = 0;
    // leap count settles by alternating estimate and lookup
    for (int k = 0; k < SETTLE_STEPS; k++) begin
      utc_ms = gps_ms - longint'(leap) * 1000;
      leap   = leap_steps_at(utc_ms);
    end
    days = floor_quot(utc_ms, MS_IN_DAY);
    msd  = utc_ms - days * MS_IN_DAY;
    // day-number split, divisions scaled to integers
    a   = JD_AT_EPOCH + days;
    b   = a + 1537;
    c   = floor_quot(100 * b - 12210, 36525);
    d   = floor_quot(1461 * c, 4);
    e   = floor_quot(10000 * (b - d), 306001);
    dom = b - d - floor_quot(306001 * e, 10000);
    mon = e - 1 - 12 * (e / 14);
    yr  = c - 4715 - floor_quot(7 + mon, 10);
    r.cal_year      = 12'(yr);
    r.cal_month     = 4'(mon);
    r.cal_day       = 5'(dom);
    r.cal_hour      = 5'(msd / 3600000);
    r.cal_minute    = 6'((msd / 60000) % 60);
    r.minute_millis = 16'(msd % 60000);
    r.leap_count    = 4'(leap);
    r.range_error   = 1'b0;
    return r;
  endfunction

  // GPS milliseconds since epoch to a (week, time of week) fix
  function automatic cal_in_t fix_from_gps_ms(input longint gps_ms);
    cal_in_t f;
    f.week_number = 16'(gps_ms / MS_IN_WEEK);
    f.week_millis = 30'(gps_ms % MS_IN_WEEK);
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: optional idle burst, then hold the transaction until taken
  // ---------------------------------------------------------------------------
  task automatic send_fix(input cal_in_t fix);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= fix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    utc_expect_q.push_back(predict_utc_date(fix));
  endtask

  // hold off the sender until every pending result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (utc_expect_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts on out_ready
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 7);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      error_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    cal_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (utc_expect_q.size() == 0) begin
        error_count++;
        $display("%0t ns: result with none pending, expected nothing, actual %p",
                 $time, out_data);
      end else begin
        want = utc_expect_q.pop_front();
        check_field("cal_year",      want.cal_year,      out_data.cal_year);
        check_field("cal_month",     want.cal_month,     out_data.cal_month);
        check_field("cal_day",       want.cal_day,       out_data.cal_day);
        check_field("cal_hour",      want.cal_hour,      out_data.cal_hour);
        check_field("cal_minute",    want.cal_minute,    out_data.cal_minute);
        check_field("minute_millis", want.minute_millis, out_data.minute_millis);
        check_field("leap_count",    want.leap_count,    out_data.leap_count);
        check_field("range_error",   want.range_error,   out_data.range_error);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic apply_reset();
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  // field extremes, full-week boundary and out-of-range week times
  task automatic test_field_extremes();
    send_fix('{week_number: 16'd0,     week_millis: 30'd0});
    send_fix('{week_number: 16'd65535, week_millis: 30'd0});
    send_fix('{week_number: 16'd0,     week_millis: 30'(MS_IN_WEEK)});
    send_fix('{week_number: 16'd65535, week_millis: 30'(MS_IN_WEEK)});
    send_fix('{week_number: 16'd100,   week_millis: 30'(MS_IN_WEEK - 1)});
    send_fix('{week_number: 16'd1234,  week_millis: 30'(MS_IN_WEEK + 1)});
    send_fix('{week_number: 16'd0,     week_millis: 30'(TOW_MAX)});
    send_fix('{week_number: 16'd65535, week_millis: 30'(TOW_MAX)});
  endtask

  // GPS time landing exactly on each leap step in UTC
  task automatic test_leap_steps();
    for (int i = 0; i < 15; i++) begin
      send_fix(fix_from_gps_ms(longint'(STEP_DAYS[i]) * MS_IN_DAY + longint'(i + 1) * 1000));
    end
  endtask

  // broad random fixes, valid and out of range
  task automatic test_random_fixes(input int count);
    cal_in_t fix;
    int      pick;
    for (int n = 0; n < count; n++) begin
      fix.week_number = ($urandom_range(0, 9) < 6) ? 16'($urandom_range(0, 2400))
                                                   : 16'($urandom_range(0, 65535));
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        fix.week_millis = 30'($urandom_range(0, 604800000));
      end else if (pick < 88) begin
        // near a day boundary within the week
        fix.week_millis = 30'(longint'($urandom_range(0, 7)) * MS_IN_DAY);
        if ($urandom_range(0, 1) && fix.week_millis != 0) fix.week_millis -= 30'd1;
      end else begin
        fix.week_millis = 30'($urandom_range(604800001, 1073741823));
      end
      send_fix(fix);
    end
  endtask

  // fixes within a few seconds of a leap step, in both week forms
  task automatic test_leap_region(input int count);
    cal_in_t fix;
    longint  gps_ms;
    int      i;
    for (int n = 0; n < count; n++) begin
      i      = $urandom_range(0, 14);
      gps_ms = longint'(STEP_DAYS[i]) * MS_IN_DAY + longint'(i) * 1000
             + longint'($urandom_range(0, 4000)) - 1000;
      fix = fix_from_gps_ms(gps_ms);
      if (fix.week_millis == 0 && $urandom_range(0, 1)) begin
        fix.week_number = fix.week_number - 16'd1;
        fix.week_millis = 30'(MS_IN_WEEK);
      end
      send_fix(fix);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    apply_reset();
    test_field_extremes();
    test_leap_steps();
    drain_results();
    test_random_fixes(550);
    drain_results();
    test_leap_region(250);
    idle_on = 1'b0;
    test_random_fixes(200);
    in_valid <= 1'b0;
    for (int n = 0; n < 5000 && utc_expect_q.size() != 0; n++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (utc_expect_q.size() != 0) begin
      error_count += utc_expect_q.size();
      $display("%0t ns: results missing, expected %0d more, actual 0",
               $time, utc_expect_q.size());
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
